@@ hw/rtl/ffba_pkg.sv @@
// Shared types, field widths and default sizes for the first-fit block allocator.
package ffba_pkg;

  localparam int REQ_SIZE_W = 15;
  localparam int ADDR_W     = 14;

  localparam int ARENA_BYTES_DEFAULT  = 16384;
  localparam int HEADER_BYTES_DEFAULT = 32;
  localparam int MAX_BLOCKS_DEFAULT   = 64;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOMEM    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

endpackage

@@ hw/rtl/ffba_if.sv @@
// Request and response channel interfaces of the block allocator.
interface ffba_req_if;
  import ffba_pkg::*;

  logic                  valid;
  logic                  ready;
  kind_e                 kind;
  logic [REQ_SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0]     release_address;

  modport source (output valid, kind, request_size, release_address, input ready);
  modport sink   (input valid, kind, request_size, release_address, output ready);
endinterface

interface ffba_rsp_if;
  import ffba_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;
  status_e           status;
  logic              reused;

  modport source (output valid, block_address, status, reused, input ready);
  modport sink   (input valid, block_address, status, reused, output ready);
endinterface

@@ hw/rtl/first_fit_block_allocator_core.sv @@
// First-fit block allocator: the block table sits in a synchronous RAM scanned one entry a cycle.
// A scan that hits ends early; otherwise every entry below the block count is read, at one read
// per cycle on the table RAM.
// One request is in work at a time; the next is taken as soon as the response is registered.
// Reset clears the break pointer, the block count and the control state; table entries are
// only read below the block count and need no clearing.
module first_fit_block_allocator_core #(
  parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEFAULT,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEFAULT,
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffba_req_if.sink   req_i,
  ffba_rsp_if.source rsp_o
);
  import ffba_pkg::*;

  localparam int BW    = $clog2(ARENA_BYTES + 1);
  localparam int AW    = $clog2(ARENA_BYTES + HEADER_BYTES + 1);
  localparam int SUMW  = $clog2(ARENA_BYTES + HEADER_BYTES + (2 ** REQ_SIZE_W) + 1);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int EW    = AW + REQ_SIZE_W + 1;
  localparam int CMPW  = (AW > ADDR_W) ? AW : ADDR_W;

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic [REQ_SIZE_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0]     raddr_q, raddr_d;
  logic [BW-1:0]         brk_q, brk_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [IW-1:0]         rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  status_e               res_status_q, res_status_d;
  logic                  res_reused_q, res_reused_d;
  logic                  out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]     out_addr_q, out_addr_d;
  status_e               out_status_q, out_status_d;
  logic                  out_reused_q, out_reused_d;

  logic                  mem_we, mem_re;
  logic [IW-1:0]         mem_waddr, mem_raddr;
  logic [EW-1:0]         mem_wdata, mem_rdata;

  logic [AW-1:0]         ent_addr;
  logic [REQ_SIZE_W-1:0] ent_size;
  logic                  ent_free;
  logic                  hit;
  logic [SUMW-1:0]       brk_sum;
  logic                  fits;
  logic [AW-1:0]         new_addr;

  ffba_table_ram #(
    .DATA_W (EW),
    .DEPTH  (MAX_BLOCKS),
    .IDX_W  (IW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign {ent_addr, ent_size, ent_free} = mem_rdata;

  // The entry read in the previous cycle is checked against the request in this one.
  always_comb begin
    if (kind_q == KIND_ALLOC) begin
      hit = rd_pend_q && ent_free && (size_q <= ent_size);
    end else begin
      hit = rd_pend_q && (CMPW'(ent_addr) == CMPW'(raddr_q));
    end
  end

  assign brk_sum  = SUMW'(brk_q) + SUMW'(HEADER_BYTES) + SUMW'(size_q);
  assign fits     = brk_sum < SUMW'(ARENA_BYTES);
  assign new_addr = AW'(brk_q) + AW'(HEADER_BYTES);

  assign req_i.ready         = (state_q == ST_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.reused        = out_reused_q;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    size_d       = size_q;
    raddr_d      = raddr_q;
    brk_d        = brk_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    res_reused_d = res_reused_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    out_reused_d = out_reused_q;
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_q;
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = idx_q[IW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          kind_d  = req_i.kind;
          size_d  = req_i.request_size;
          raddr_d = req_i.release_address;
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_q;
          mem_wdata = {ent_addr, ent_size, kind_q == KIND_RELEASE};
          res_status_d = STATUS_OK;
          if (kind_q == KIND_ALLOC) begin
            res_addr_d   = ADDR_W'(ent_addr);
            res_reused_d = 1'b1;
          end else begin
            res_addr_d   = '0;
            res_reused_d = 1'b0;
          end
          state_d = ST_RESULT;
        end else if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = idx_q[IW-1:0];
          idx_d     = idx_q + CW'(1);
        end else begin
          // Every entry below the count has been checked without a match.
          res_addr_d   = '0;
          res_reused_d = 1'b0;
          state_d      = ST_RESULT;
          if (kind_q == KIND_RELEASE) begin
            res_status_d = STATUS_NOTFOUND;
          end else if (cnt_q == CW'(MAX_BLOCKS)) begin
            res_status_d = STATUS_FULL;
          end else if (!fits) begin
            res_status_d = STATUS_NOMEM;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = cnt_q[IW-1:0];
            mem_wdata    = {new_addr, size_q, 1'b0};
            brk_d        = BW'(brk_sum);
            cnt_d        = cnt_q + CW'(1);
            res_addr_d   = ADDR_W'(new_addr);
            res_status_d = STATUS_OK;
          end
        end
      end

      ST_RESULT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          out_reused_d = res_reused_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      brk_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      brk_q       <= brk_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    size_q       <= size_d;
    raddr_q      <= raddr_d;
    rd_idx_q     <= rd_idx_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    res_reused_q <= res_reused_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
    out_reused_q <= out_reused_d;
  end

endmodule

@@ hw/rtl/ffba_table_ram.sv @@
// Block table storage: one write port and one registered read port.
module ffba_table_ram #(
  parameter int DATA_W = 30,
  parameter int DEPTH  = 64,
  parameter int IDX_W  = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
